/* sv/scfd_pkg.sv */
`default_nettype none

package scfd_pkg;

    // Framing bytes of the serial protocol.
    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] END_BYTE   = 8'h55;

    // Info byte layout: DLC in the low nibble, extended flag in bit 5.
    localparam int DLC_W       = 4;
    localparam int EXT_BIT_POS = 5;

    // Frame overhead beyond the payload, shortest closing length, and first payload position.
    localparam int EXT_OVERHEAD = 7;
    localparam int STD_OVERHEAD = 5;
    localparam int MIN_CLOSE    = 5;
    localparam int FIRST_EXT    = 6;
    localparam int FIRST_STD    = 4;

    localparam int ID_W   = 32;
    localparam int BYTE_W = 8;

    // Default store size per frame buffer.
    localparam int MAX_FRAME_BYTES_DEF = 22;

    // One closed frame handed from the front to the back.
    typedef struct packed {
        logic              err;
        logic              ext;
        logic [DLC_W-1:0]  dlc;
        logic [ID_W-1:0]   id;
        logic              bank;
    } job_t;

    // Back tells the front that a frame buffer has been drained.
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

endpackage

`default_nettype wire

/* sv/scfd_in_if.sv */
`default_nettype none

interface scfd_in_if import scfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* sv/scfd_out_if.sv */
`default_nettype none

interface scfd_out_if import scfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              record_kind;
    logic              status;
    logic [ID_W-1:0]   frame_id;
    logic              is_extended;
    logic [DLC_W-1:0]  data_count;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (
        output valid, output record_kind, output status, output frame_id,
        output is_extended, output data_count, output data_byte, output last,
        input ready
    );
    modport sink (
        input valid, input record_kind, input status, input frame_id,
        input is_extended, input data_count, input data_byte, input last,
        output ready
    );
endinterface

`default_nettype wire

/* sv/serial_can_frame_deframer.sv */
// A closed frame's job is popped by the back, which then offers its header or error record.
// Data records follow one per ready cycle from a double-buffered store with a registered read port.
// Throughput: one byte per cycle; intake stalls while the next buffer is still being drained.
// It also stalls while both job queue entries are full.
// Reset clears the framing state, buffer ownership, job queue and output register at once.
// Store contents stay undefined after reset and get no clearing pass.
`default_nettype none

module serial_can_frame_deframer import scfd_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    scfd_in_if.sink    rx,
    scfd_out_if.source tx
);

    localparam int IW        = $clog2(MAX_FRAME_BYTES);
    localparam int RAM_DEPTH = 2 * (2 ** IW);

    logic           q_push;
    job_t           push_job;
    logic           q_full;
    logic           q_pop;
    logic           q_valid;
    job_t           head_job;
    bank_rel_t      rel;
    logic           wr_en;
    logic [IW:0]    wr_addr;
    logic [7:0]     wr_data;
    logic           rd_en;
    logic [IW:0]    rd_addr;
    logic [7:0]     rd_data;

    scfd_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .q_push  (q_push),
        .q_job   (push_job),
        .q_full  (q_full),
        .rel     (rel),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    scfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_job)
    );

    scfd_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    scfd_back #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (head_job),
        .q_pop   (q_pop),
        .rel     (rel),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .tx      (tx)
    );

endmodule

`default_nettype wire

/* sv/scfd_ram.sv */
`default_nettype none

module scfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/scfd_front.sv */
`default_nettype none

module scfd_front import scfd_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    scfd_in_if.sink                                 rx,
    output logic                                    q_push,
    output job_t                                    q_job,
    input  wire logic                               q_full,
    input  wire bank_rel_t                          rel,
    output logic                                    wr_en,
    output logic [$clog2(MAX_FRAME_BYTES):0]        wr_addr,
    output logic [BYTE_W-1:0]                       wr_data
);

    localparam int IW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = $clog2(MAX_FRAME_BYTES + 2);

    logic              in_frame_reg, in_frame_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              wr_bank_reg, wr_bank_next;
    logic [1:0]        busy_reg, busy_next;
    logic [BYTE_W-1:0] info_reg, info_next;
    logic [ID_W-1:0]   id_reg, id_next;

    logic              accept;
    logic [CW-1:0]     cnt_new;
    logic [CW-1:0]     expect_len;
    logic              info_ext;
    logic [DLC_W-1:0]  info_dlc;
    logic              len_err;

    // The current buffer must be free and the queue must have room.
    assign rx.ready = !busy_reg[wr_bank_reg] && !q_full;
    assign accept   = rx.valid && rx.ready;

    assign info_ext   = info_reg[EXT_BIT_POS];
    assign info_dlc   = info_reg[DLC_W-1:0];
    assign expect_len = CW'(info_dlc) + (info_ext ? CW'(EXT_OVERHEAD) : CW'(STD_OVERHEAD));

    // Count after this byte, saturating one past the store.
    assign cnt_new = (count_reg < CW'(MAX_FRAME_BYTES)) ? count_reg + CW'(1)
                                                        : CW'(MAX_FRAME_BYTES + 1);
    assign len_err = (cnt_new != expect_len);

    // Byte intake, header capture, frame close and buffer release.
    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        wr_bank_next  = wr_bank_reg;
        busy_next     = busy_reg;
        info_next     = info_reg;
        id_next       = id_reg;
        q_push        = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = {wr_bank_reg, count_reg[IW-1:0]};
        wr_data       = rx.rx_byte;

        q_job.err  = len_err;
        q_job.ext  = info_ext;
        q_job.dlc  = info_dlc;
        q_job.id   = info_ext ? id_reg : {16'h0000, id_reg[15:0]};
        q_job.bank = wr_bank_reg;

        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept)
        begin
            if (rx.rx_byte == START_BYTE)
            begin
                in_frame_next = 1'b1;
                count_next    = CW'(1);
            end
            else if (in_frame_reg)
            begin
                count_next = cnt_new;
                if (count_reg < CW'(MAX_FRAME_BYTES))
                begin
                    wr_en = 1'b1;
                    unique case (count_reg)
                        CW'(1):  info_next      = rx.rx_byte;
                        CW'(2):  id_next[7:0]   = rx.rx_byte;
                        CW'(3):  id_next[15:8]  = rx.rx_byte;
                        CW'(4):  id_next[23:16] = rx.rx_byte;
                        CW'(5):  id_next[31:24] = rx.rx_byte;
                        default: ;
                    endcase
                end
                if (rx.rx_byte == END_BYTE && cnt_new >= CW'(MIN_CLOSE))
                begin
                    q_push        = 1'b1;
                    in_frame_next = 1'b0;
                    count_next    = '0;
                    // A good frame holds its buffer until the back drains it.
                    if (!len_err)
                    begin
                        busy_next[wr_bank_reg] = 1'b1;
                        wr_bank_next           = !wr_bank_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            wr_bank_reg  <= 1'b0;
            busy_reg     <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            wr_bank_reg  <= wr_bank_next;
            busy_reg     <= busy_next;
        end
    end

    // Header bytes need no reset.
    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
        id_reg   <= id_next;
    end

endmodule

`default_nettype wire

/* sv/scfd_queue.sv */
`default_nettype none

module scfd_queue import scfd_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output logic      valid,
    output job_t      head
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    job_t            entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]   count_reg;

    assign full  = (count_reg == NW'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // The front never pushes into a full queue, and the back never pops an empty one.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("job queue underflow");

endmodule

`default_nettype wire

/* sv/scfd_back.sv */
`default_nettype none

module scfd_back import scfd_pkg::*; #(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_valid,
    input  wire job_t                               q_job,
    output logic                                    q_pop,
    output bank_rel_t                               rel,
    output logic                                    rd_en,
    output logic [$clog2(MAX_FRAME_BYTES):0]        rd_addr,
    input  wire logic [BYTE_W-1:0]                  rd_data,
    scfd_out_if.source                              tx
);

    localparam int IW = $clog2(MAX_FRAME_BYTES);

    typedef enum logic {
        B_IDLE,
        B_DATA
    } state_t;

    state_t            state_reg, state_next;
    job_t              job_reg, job_next;
    logic [IW-1:0]     rd_idx_reg, rd_idx_next;
    logic [DLC_W-1:0]  remain_reg, remain_next;

    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, kind_next;
    logic              status_reg, status_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic              ext_reg, ext_next;
    logic [DLC_W-1:0]  dlc_reg, dlc_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;

    logic              load_ok;
    logic [IW-1:0]     first_idx;

    assign load_ok   = !out_valid_reg || tx.ready;
    assign first_idx = q_job.ext ? IW'(FIRST_EXT) : IW'(FIRST_STD);

    // Record sequencer: header or error record, then the payload bytes.
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        rd_idx_next    = rd_idx_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && !tx.ready;
        kind_next      = kind_reg;
        status_next    = status_reg;
        id_next        = id_reg;
        ext_next       = ext_reg;
        dlc_next       = dlc_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        rel            = '0;
        rd_en          = 1'b0;
        rd_addr        = {q_job.bank, first_idx};

        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid && load_ok)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = 1'b0;
                    status_next    = q_job.err;
                    id_next        = q_job.err ? '0 : q_job.id;
                    ext_next       = q_job.ext;
                    dlc_next       = q_job.dlc;
                    data_next      = '0;
                    if (q_job.err)
                    begin
                        last_next = 1'b1;
                    end
                    else if (q_job.dlc == '0)
                    begin
                        last_next = 1'b1;
                        rel.valid = 1'b1;
                        rel.bank  = q_job.bank;
                    end
                    else
                    begin
                        // Fetch the first payload byte behind the header.
                        last_next   = 1'b0;
                        rd_en       = 1'b1;
                        rd_idx_next = first_idx + IW'(1);
                        remain_next = q_job.dlc - DLC_W'(1);
                        job_next    = q_job;
                        state_next  = B_DATA;
                    end
                end
            end
            B_DATA:
            begin
                rd_addr = {job_reg.bank, rd_idx_reg};
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = 1'b1;
                    status_next    = 1'b0;
                    id_next        = job_reg.id;
                    ext_next       = job_reg.ext;
                    dlc_next       = job_reg.dlc;
                    data_next      = rd_data;
                    last_next      = (remain_reg == '0);
                    if (remain_reg == '0)
                    begin
                        rel.valid  = 1'b1;
                        rel.bank   = job_reg.bank;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        rd_en       = 1'b1;
                        rd_idx_next = rd_idx_reg + IW'(1);
                        remain_next = remain_reg - DLC_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            job_reg       <= '0;
            rd_idx_reg    <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= 1'b0;
            status_reg    <= 1'b0;
            id_reg        <= '0;
            ext_reg       <= 1'b0;
            dlc_reg       <= '0;
            data_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            rd_idx_reg    <= rd_idx_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            status_reg    <= status_next;
            id_reg        <= id_next;
            ext_reg       <= ext_next;
            dlc_reg       <= dlc_next;
            data_reg      <= data_next;
            last_reg      <= last_next;
        end
    end

    assign tx.valid       = out_valid_reg;
    assign tx.record_kind = kind_reg;
    assign tx.status      = status_reg;
    assign tx.frame_id    = id_reg;
    assign tx.is_extended = ext_reg;
    assign tx.data_count  = dlc_reg;
    assign tx.data_byte   = data_reg;
    assign tx.last        = last_reg;

    // A data record never carries an error, and an error record always ends its run.
    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.record_kind |-> !tx.status)
        else $error("data record flagged as error");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.status |-> tx.last && tx.frame_id == '0)
        else $error("error record malformed");

endmodule

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench;
    import scfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES      = MAX_FRAME_BYTES_DEF;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int MAX_PRINTED    = 40;

    // Record kind and status codes as seen on the result channel.
    localparam logic REC_FRAME    = 1'b0;
    localparam logic REC_DATA     = 1'b1;
    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_BAD_LEN = 1'b1;

    typedef enum logic [1:0] {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} pace_t;

    typedef struct packed {
        logic              kind;
        logic              status;
        logic [ID_W-1:0]   id;
        logic              ext;
        logic [DLC_W-1:0]  dlc;
        logic [BYTE_W-1:0] data;
        logic              last;
    } can_record_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              hold_rx;
        logic              wait_idle;
    } serial_beat_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    scfd_in_if  rx_if ();
    scfd_out_if tx_if ();

    serial_can_frame_deframer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .tx    (tx_if)
    );

    // Testbench-owned drive variables, known from time zero.
    logic              drv_valid = 1'b0;
    logic [BYTE_W-1:0] drv_byte  = '0;
    serial_beat_t      drv_beat  = '0;
    logic              mon_ready = 1'b0;

    assign rx_if.valid   = drv_valid;
    assign rx_if.rx_byte = drv_byte;
    assign tx_if.ready   = mon_ready;

    pace_t         pace = IDLE_RX_HEAVY;
    serial_beat_t  serial_bytes [$];
    can_record_t   due_records [$];
    int unsigned   records_due  = 0;
    int unsigned   records_seen = 0;
    int unsigned   rx_hold_left = 0;
    int unsigned   fail_count   = 0;

    // Deframer state as the testbench tracks it.
    logic              frame_open = 1'b0;
    int unsigned       held       = 0;
    logic [BYTE_W-1:0] frame_bytes [MAX_BYTES];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        if (fail_count < MAX_PRINTED)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    // Checks a closed frame's length and queues the records it yields.
    function automatic void close_frame();
        logic [BYTE_W-1:0] info;
        logic              ext;
        logic [DLC_W-1:0]  dlc;
        int unsigned       want_len;
        int unsigned       first;
        can_record_t       rec;
        info     = frame_bytes[1];
        dlc      = info[DLC_W-1:0];
        ext      = info[EXT_BIT_POS];
        want_len = int'(dlc) + (ext ? EXT_OVERHEAD : STD_OVERHEAD);
        rec      = '0;
        rec.ext  = ext;
        rec.dlc  = dlc;
        if (held != want_len)
        begin
            rec.kind   = REC_FRAME;
            rec.status = STAT_BAD_LEN;
            rec.last   = 1'b1;
            due_records = {due_records, rec};
            records_due++;
        end
        else
        begin
            if (ext)
            begin
                rec.id = {frame_bytes[5], frame_bytes[4], frame_bytes[3], frame_bytes[2]};
                first  = FIRST_EXT;
            end
            else
            begin
                rec.id = {16'h0000, frame_bytes[3], frame_bytes[2]};
                first  = FIRST_STD;
            end
            rec.kind   = REC_FRAME;
            rec.status = STAT_OK;
            rec.last   = (dlc == 0);
            due_records = {due_records, rec};
            records_due++;
            for (int i = 0; i < int'(dlc); i++)
            begin
                rec.kind = REC_DATA;
                rec.data = frame_bytes[first + i];
                rec.last = (i == int'(dlc) - 1);
                due_records = {due_records, rec};
                records_due++;
            end
        end
    endfunction

    // Advances the framing state by one received byte.
    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        if (b == START_BYTE)
        begin
            frame_open     = 1'b1;
            frame_bytes[0] = b;
            held           = 1;
        end
        else if (frame_open)
        begin
            if (held < MAX_BYTES)
            begin
                frame_bytes[held] = b;
                held++;
            end
            else
            begin
                held = MAX_BYTES + 1;
            end
            if (b == END_BYTE && held >= MIN_CLOSE)
            begin
                close_frame();
                frame_open = 1'b0;
                held       = 0;
            end
        end
    endfunction

    // Sender: one beat on the bus until taken, then the next queued byte or a gap.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        logic offer;
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_byte  <= '0;
            drv_beat  <= '0;
        end
        else
        begin
            if (drv_valid && rx_if.ready)
            begin
                deframe_byte(drv_byte);
            end
            if (!drv_valid || rx_if.ready)
            begin
                offer = 1'b0;
                if (serial_bytes.size() != 0)
                begin
                    case (pace)
                        IDLE_RX_HEAVY: offer = ($urandom_range(99) >= 11);
                        IDLE_TX_HEAVY: offer = ($urandom_range(99) >= 59);
                        default:       offer = 1'b1;
                    endcase
                    if (serial_bytes[0].wait_idle && records_due != records_seen)
                    begin
                        offer = 1'b0;
                    end
                end
                if (offer)
                begin
                    drv_beat  <= serial_bytes[0];
                    drv_byte  <= serial_bytes[0].data;
                    drv_valid <= 1'b1;
                    void'(serial_bytes.pop_front());
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, started when a marked byte is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold_left <= 0;
        end
        else if (drv_valid && rx_if.ready && drv_beat.hold_rx)
        begin
            rx_hold_left <= RX_HOLD_CYCLES;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    task automatic compare_field(input string name, input logic [ID_W-1:0] got,
                                 input logic [ID_W-1:0] want);
        if (got !== want)
        begin
            note_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    // Receiver: checks each taken record against the oldest outstanding one.
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        can_record_t want;
        if (!rst_n)
        begin
            mon_ready <= 1'b0;
        end
        else
        begin
            if (tx_if.valid && mon_ready)
            begin
                records_seen <= records_seen + 1;
                if (due_records.size() == 0)
                begin
                    note_mismatch("record arrived with none outstanding");
                end
                else
                begin
                    want = due_records.pop_front();
                    compare_field("record_kind", ID_W'(tx_if.record_kind), ID_W'(want.kind));
                    compare_field("status", ID_W'(tx_if.status), ID_W'(want.status));
                    compare_field("frame_id", tx_if.frame_id, want.id);
                    compare_field("is_extended", ID_W'(tx_if.is_extended), ID_W'(want.ext));
                    compare_field("data_count", ID_W'(tx_if.data_count), ID_W'(want.dlc));
                    compare_field("data_byte", ID_W'(tx_if.data_byte), ID_W'(want.data));
                    compare_field("last", ID_W'(tx_if.last), ID_W'(want.last));
                end
            end
            if (rx_hold_left != 0)
            begin
                mon_ready <= 1'b0;
            end
            else
            begin
                case (pace)
                    IDLE_RX_HEAVY: mon_ready <= ($urandom_range(99) >= 59);
                    IDLE_TX_HEAVY: mon_ready <= ($urandom_range(99) >= 11);
                    default:       mon_ready <= 1'b1;
                endcase
            end
        end
    end

    function automatic void push_byte(input logic [BYTE_W-1:0] b, input logic hold_rx,
                                      input logic wait_idle);
        serial_beat_t beat;
        beat.data      = b;
        beat.hold_rx   = hold_rx;
        beat.wait_idle = wait_idle;
        serial_bytes = {serial_bytes, beat};
    endfunction

    // Random payload byte; framing bytes appear only with the given percentage.
    function automatic logic [BYTE_W-1:0] body_byte(input int mark_pct);
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        if (b == START_BYTE || b == END_BYTE)
        begin
            b ^= 8'h01;
        end
        if (int'($urandom_range(99)) < mark_pct)
        begin
            b = $urandom_range(1) ? START_BYTE : END_BYTE;
        end
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] make_info(input logic ext, input logic [DLC_W-1:0] dlc);
        logic [BYTE_W-1:0] info;
        info                 = BYTE_W'($urandom);
        info[DLC_W-1:0]      = dlc;
        info[EXT_BIT_POS]    = ext;
        if (info == START_BYTE)
        begin
            info[7] = 1'b0;
        end
        return info;
    endfunction

    // Queues start, info, ID and payload bytes (length off by extra) and the end byte.
    // A negative fill picks random body bytes.
    function automatic int add_frame(input logic [BYTE_W-1:0] info, input int extra,
                                     input int fill, input int mark_pct,
                                     input logic hold_rx, input logic wait_idle);
        int n_body;
        n_body = (info[EXT_BIT_POS] ? FIRST_EXT - 2 : FIRST_STD - 2)
               + int'(info[DLC_W-1:0]) + extra;
        if (n_body < 0)
        begin
            n_body = 0;
        end
        push_byte(START_BYTE, hold_rx, wait_idle);
        push_byte(info, 1'b0, 1'b0);
        for (int i = 0; i < n_body; i++)
        begin
            push_byte((fill < 0) ? body_byte(mark_pct) : BYTE_W'(fill), 1'b0, 1'b0);
        end
        push_byte(END_BYTE, 1'b0, 1'b0);
        return n_body + 3;
    endfunction

    task automatic add_directed_frames();
        int unused;
        // Bytes with no frame open are ignored.
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(END_BYTE, 1'b0, 1'b0);
        // Empty payloads, standard and extended.
        unused = add_frame(8'h00, 0, 8'h00, 0, 1'b0, 1'b0);
        unused = add_frame(8'hE0, 0, -1, 0, 1'b0, 1'b0);
        // Largest payloads; the extended one fills the whole store.
        unused = add_frame(8'h2F, 0, 8'hFF, 0, 1'b0, 1'b0);
        unused = add_frame(8'hDF, 0, 8'h00, 0, 1'b0, 1'b0);
        // An info byte equal to the end byte does not close the frame yet.
        unused = add_frame(END_BYTE, 0, -1, 0, 1'b0, 1'b0);
        // A start byte inside a frame discards it.
        push_byte(START_BYTE, 1'b0, 1'b0);
        push_byte(8'h08, 1'b0, 1'b0);
        push_byte(8'h12, 1'b0, 1'b0);
        unused = add_frame(8'h03, 0, -1, 0, 1'b0, 1'b0);
        // A payload end byte closes the frame early; trailing bytes are ignored.
        push_byte(START_BYTE, 1'b0, 1'b0);
        push_byte(8'h04, 1'b0, 1'b0);
        push_byte(8'h34, 1'b0, 1'b0);
        push_byte(8'h12, 1'b0, 1'b0);
        push_byte(END_BYTE, 1'b0, 1'b0);
        push_byte(8'h66, 1'b0, 1'b0);
        push_byte(8'h77, 1'b0, 1'b0);
        // Store overflow, then frames one byte short and one byte long.
        unused = add_frame(8'h2F, 6, 8'h11, 0, 1'b0, 1'b0);
        unused = add_frame(8'h21, -1, -1, 0, 1'b0, 1'b0);
        unused = add_frame(8'h13, 1, -1, 0, 1'b0, 1'b0);
    endtask

    // Mostly well-formed frames with random content, plus broken ones and noise.
    task automatic add_random_frames(input int budget, input logic hold_first);
        int               added;
        int               pick;
        int               extra;
        int               n_part;
        logic             ext;
        logic [DLC_W-1:0] dlc;
        added = 0;
        if (hold_first)
        begin
            added += add_frame(make_info(1'b1, 4'h8), 0, -1, 0, 1'b1, 1'b0);
        end
        while (added < budget)
        begin
            pick = $urandom_range(99);
            ext  = 1'($urandom_range(1));
            dlc  = ($urandom_range(3) == 0) ? DLC_W'($urandom) : DLC_W'($urandom_range(6));
            if (pick < 64)
            begin
                added += add_frame(make_info(ext, dlc), 0, -1, 0, 1'b0, 1'b0);
            end
            else if (pick < 76)
            begin
                extra  = $urandom_range(1) ? 1 : -1;
                extra *= $urandom_range(1, 3);
                added += add_frame(make_info(ext, dlc), extra, -1, 0, 1'b0, 1'b0);
            end
            else if (pick < 81)
            begin
                extra  = 18 - int'(dlc) + $urandom_range(4);
                added += add_frame(make_info(ext, dlc), extra, -1, 0, 1'b0, 1'b0);
            end
            else if (pick < 88)
            begin
                added += add_frame(make_info(ext, dlc), 0, -1, 12, 1'b0, 1'b0);
            end
            else if (pick < 94)
            begin
                n_part = $urandom_range(1, 4);
                push_byte(START_BYTE, 1'b0, 1'b0);
                push_byte(make_info(ext, dlc), 1'b0, 1'b0);
                for (int i = 0; i < n_part; i++)
                begin
                    push_byte(body_byte(0), 1'b0, 1'b0);
                end
                added += n_part + 2;
                added += add_frame(make_info(~ext, dlc), 0, -1, 0, 1'b0, 1'b0);
            end
            else
            begin
                n_part = $urandom_range(1, 3);
                for (int i = 0; i < n_part; i++)
                begin
                    push_byte(BYTE_W'($urandom), 1'b0, 1'b0);
                end
                added += n_part;
            end
        end
    endtask

    task automatic wait_drained();
        while (serial_bytes.size() != 0 || drv_valid || due_records.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin : stimulus_proc
        int unused;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sender mostly busy, receiver often stalled.
        pace = IDLE_RX_HEAVY;
        add_directed_frames();
        add_random_frames(75, 1'b0);
        wait_drained();

        // Sender often idle, receiver mostly ready.
        pace = IDLE_TX_HEAVY;
        add_random_frames(75, 1'b0);
        wait_drained();

        // Full rate, opened by a long receiver hold-off, with one pause to drain.
        pace = IDLE_NONE;
        add_random_frames(30, 1'b1);
        unused = add_frame(make_info(1'b0, 4'h5), 0, -1, 0, 1'b0, 1'b1);
        add_random_frames(30, 1'b0);
        wait_drained();

        repeat (16) @(negedge clk);
        if (due_records.size() != 0)
        begin
            note_mismatch($sformatf("%0d records never arrived", due_records.size()));
        end
        if (fail_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout: %0d records outstanding", due_records.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
